FILE: sv/art_pkg.sv
// Package: shared constants and types of the ack request tracker.
`default_nettype none
package art_pkg;
   localparam int MaxRequests = 8;
   localparam int MaxDevices  = 32;
   localparam int IdxW = $clog2(MaxRequests);
   localparam int CntW = $clog2(MaxRequests + 1);

   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_ACK  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   localparam logic [2:0] EV_ADDED   = 3'd0;
   localparam logic [2:0] EV_FULL    = 3'd1;
   localparam logic [2:0] EV_MATCHED = 3'd2;
   localparam logic [2:0] EV_NOMATCH = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;

   localparam logic [0:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [0:0] CSR_TIMEOUT_CODE  = 1'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [10:0] msg_id;
      logic [5:0]  acks_wanted;
      logic        wants_report;
      logic [4:0]  device;
      logic [7:0]  ack_status;
      logic        host_rejects;
   } req_type_t_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [10:0] out_msg_id;
      logic [4:0]  out_device;
      logic [7:0]  out_status;
      logic [5:0]  remaining;
      logic        closed;
      logic        reported;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [10:0] msg_id;
      logic [5:0]  remaining;
      logic [31:0] answered;
      logic [15:0] age;
      logic        report;
   } entry_type;
endpackage
`default_nettype wire

FILE: sv/art_if.sv
// Interfaces: request and response valid/ready channels.
`default_nettype none
interface art_req_if import art_pkg::*; ();
   logic valid;
   logic ready;
   req_type_t_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/ack_request_tracker.sv
// Top level: ack request tracker with an entry table walked one slot per cycle, which
// stalls where a result must wait on the output register. The block is ready only in
// its idle state and takes one transaction at a time. An add is accepted, then writes
// the entry and loads the result. An ack compares one entry per cycle; a miss walks the
// whole table, and a closing hit shifts the later entries down one per cycle. A tick
// ages all entries in one step, then walks the table; every expiry costs a compare plus
// a shift of each entry from it to the end of the table. A new result waits while the
// output register still holds an untaken one. A tick result is staged one step so its
// last flag is known when it leaves.
`default_nettype none
module ack_request_tracker import art_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   art_req_if.sink     req,
   art_rsp_if.source   rsp,
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ADD   = 5'b00010,
      S_AGE   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_SHIFT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   entry_type tab_ff [MaxRequests];
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] ptr_ff, ptr_in;
   logic [CntW-1:0] sptr_ff, sptr_in;
   req_type_t_type item_ff, item_in;
   logic [15:0] tticks_ff;
   logic [7:0] tcode_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type pend_ff, pend_in;
   logic pend_v_ff, pend_v_in;

   // shared entry unit: compares the entry under the pointer
   entry_type cur;
   logic ptr_in_range, id_hit, bit_set, expired, rej, ack_hit, table_full, out_free;
   logic ack_commit;
   logic [5:0] dec_rem, new_rem, nexp;
   logic [IdxW-1:0] pidx, sidx, sidx_next;
   logic [CntW-1:0] snext;
   rsp_type walk_rsp;

   assign pidx = ptr_ff[IdxW-1:0];
   assign ptr_in_range = ptr_ff < count_ff;
   assign cur = tab_ff[pidx];
   assign id_hit = cur.msg_id == item_ff.msg_id;
   assign bit_set = cur.answered[item_ff.device];
   assign ack_hit = id_hit && !bit_set;
   assign expired = cur.age >= tticks_ff;
   assign rej = cur.report & item_ff.host_rejects;
   assign dec_rem = (cur.remaining != 6'd0) ? cur.remaining - 6'd1 : 6'd0;
   assign new_rem = rej ? cur.remaining : dec_rem;
   assign table_full = count_ff >= CntW'(MaxRequests);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign ack_commit = (state_ff == S_SCAN) && (item_ff.req_type == REQ_ACK) &&
                       ptr_in_range && ack_hit && out_free;

   assign snext = sptr_ff + 1'b1;
   assign sidx = sptr_ff[IdxW-1:0];
   assign sidx_next = snext[IdxW-1:0];

   assign nexp = (item_ff.acks_wanted > 6'(MaxDevices)) ? 6'(MaxDevices)
                                                         : item_ff.acks_wanted;

   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // result of a matching ack or an expiry at the pointer
   always_comb begin
      walk_rsp = '0;
      walk_rsp.out_msg_id = cur.msg_id;
      walk_rsp.remaining = new_rem;
      walk_rsp.reported = cur.report;
      if (item_ff.req_type == REQ_ACK) begin
         walk_rsp.event_res = EV_MATCHED;
         walk_rsp.out_device = item_ff.device;
         walk_rsp.out_status = item_ff.ack_status;
         walk_rsp.closed = (new_rem == 6'd0) || (item_ff.ack_status == tcode_ff);
         walk_rsp.last = 1'b1;
      end else begin
         walk_rsp.event_res = EV_TIMEOUT;
         walk_rsp.out_status = tcode_ff;
         walk_rsp.closed = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      sptr_in = sptr_ff;
      item_in = item_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               item_in = req.data;
               ptr_in = '0;
               case (req.data.req_type)
                  REQ_ADD:  state_in = S_ADD;
                  REQ_ACK:  state_in = S_SCAN;
                  REQ_TICK: state_in = S_AGE;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (out_free) begin
               rsp_in = '0;
               rsp_in.event_res = table_full ? EV_FULL : EV_ADDED;
               rsp_in.out_msg_id = item_ff.msg_id;
               rsp_in.remaining = nexp;
               rsp_in.reported = item_ff.wants_report;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               if (!table_full) count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         S_AGE: begin
            // every entry ages in one step (independent lanes)
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!ptr_in_range) begin
               if (item_ff.req_type == REQ_ACK) begin
                  if (out_free) begin
                     rsp_in = '0;
                     rsp_in.event_res = EV_NOMATCH;
                     rsp_in.out_msg_id = item_ff.msg_id;
                     rsp_in.out_device = item_ff.device;
                     rsp_in.out_status = item_ff.ack_status;
                     rsp_in.last = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
               end else if (!pend_v_ff) begin
                  // quiet tick
                  state_in = S_IDLE;
               end else if (out_free) begin
                  rsp_in = pend_ff;
                  rsp_in.last = 1'b1;
                  rsp_valid_in = 1'b1;
                  pend_v_in = 1'b0;
                  state_in = S_IDLE;
               end
            end else if (item_ff.req_type == REQ_ACK) begin
               if (!ack_hit) begin
                  ptr_in = ptr_ff + 1'b1;
               end else if (out_free) begin
                  rsp_in = walk_rsp;
                  rsp_valid_in = 1'b1;
                  sptr_in = ptr_ff;
                  state_in = walk_rsp.closed ? S_SHIFT : S_IDLE;
               end
            end else if (!expired) begin
               ptr_in = ptr_ff + 1'b1;
            end else if (!pend_v_ff || out_free) begin
               // earlier expiry leaves now, this one waits for the walk to go on
               if (pend_v_ff) begin
                  rsp_in = pend_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_in = walk_rsp;
               pend_v_in = 1'b1;
               sptr_in = ptr_ff;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // move one entry down per cycle; the tick walk resumes at the vacated slot
            if (snext < count_ff) begin
               sptr_in = snext;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = (item_ff.req_type == REQ_ACK) ? S_IDLE : S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ptr_ff <= '0;
         sptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         tticks_ff <= 16'd25;
         tcode_ff <= 8'd3;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         sptr_ff <= sptr_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff <= pend_v_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT_TICKS: tticks_ff <= csr_wdata;
               CSR_TIMEOUT_CODE:  tcode_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff <= rsp_in;
      pend_ff <= pend_in;
   end

   // entry table
   always_ff @(posedge clock) begin
      case (state_ff)
         S_ADD: begin
            if (out_free && !table_full) begin
               tab_ff[count_ff[IdxW-1:0]] <= '{msg_id: item_ff.msg_id, remaining: nexp,
                  answered: '0, age: '0, report: item_ff.wants_report};
            end
         end
         S_AGE: begin
            for (int k = 0; k < MaxRequests; k++) begin
               if (tab_ff[k].age != 16'hFFFF) tab_ff[k].age <= tab_ff[k].age + 16'd1;
            end
         end
         S_SCAN: begin
            if (ack_commit) begin
               tab_ff[pidx].answered[item_ff.device] <= 1'b1;
               tab_ff[pidx].remaining <= new_rem;
            end
         end
         S_SHIFT: begin
            if (snext < count_ff) tab_ff[sidx] <= tab_ff[sidx_next];
         end
         default: ;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxRequests)) else $error("entry count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("response changed while stalled");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
endmodule
`default_nettype wire
